/* src/swm_pkg.sv */
// Shared constants and helpers for the sliding-window median filter.
package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int WINDOW_DEFAULT = 8;

    // Mean of the two middle values: 33-bit sum, arithmetic shift, floor rounding.
    function automatic logic signed [SAMPLE_W-1:0] floor_half_sum(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] sum;
        sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        return sum[SAMPLE_W:1];
    endfunction

endpackage

/* src/sliding_window_median_top.sv */
// Top level of the sliding-window running median filter.
//
// Usage:
//   Input channel s_*: one signed Q16.16 sample per request on s_tdata.
//   Output channel m_*: one signed Q16.16 median per accepted sample, in order.
//   The window holds the last WINDOW samples; after reset it holds WINDOW zeros,
//   which take part in the median until overwritten.
//   Odd WINDOW: middle sorted value. Even WINDOW: floor of the mean of the two
//   middle values.
// Path: a sample accepted into the chain cells reaches m_tdata through the median
//   tap register m_tdata_reg, which loads once the output is free.
// Throughput: one sample per cycle while m_tready keeps the output free. Each cell of the
//   sorted chain updates from its two neighbors, so one shift step per sample sets the rate.
// Stall: while a result waits on a low m_tready, one more sample is taken into
//   the chain; after that s_tready drops until the output register frees up.
// Reset: synchronous, active-low aresetn clears the chain to zeros, the ages to
//   the ring order and both valid flags; the block takes samples on the next cycle.
module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata    // [31:0] median
);

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic signed [SAMPLE_W-1:0] cell_val [WINDOW];
    logic [AGE_W-1:0]           cell_age [WINDOW];
    logic [WINDOW-1:0]          cell_gt;
    logic [WINDOW-1:0]          cell_oldest;

    logic                       pend_reg;    // chain holds a median not yet taken
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_tdata_reg, m_tdata_next;

    logic                       s_accept;
    logic                       out_load;
    logic [AGE_W-1:0]           rem_idx;     // index of the entry to evict

    assign out_load = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    // Exactly one cell is oldest; its index comes out of an OR tree.
    always_comb begin
        rem_idx = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rem_idx = rem_idx | (cell_oldest[i] ? AGE_W'(i) : AGE_W'(0));
        end
    end

    // Sorted chain, ascending from cell 0. Ends see -inf on the left, +inf on the right.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        logic signed [SAMPLE_W-1:0] lv, rv;
        logic [AGE_W-1:0]           la, ra;
        logic                       lg, rg, rle_self, rle_left;

        if (i == 0) begin : g_first
            assign lv       = '0;
            assign la       = '0;
            assign lg       = 1'b0;
            assign rle_left = 1'b0;
        end else begin : g_mid_l
            assign lv       = cell_val[i-1];
            assign la       = cell_age[i-1];
            assign lg       = cell_gt[i-1];
            assign rle_left = rem_idx <= AGE_W'(i - 1);
        end

        if (i == WINDOW - 1) begin : g_last
            assign rv = '0;
            assign ra = '0;
            assign rg = 1'b1;
        end else begin : g_mid_r
            assign rv = cell_val[i+1];
            assign ra = cell_age[i+1];
            assign rg = cell_gt[i+1];
        end

        assign rle_self = rem_idx <= AGE_W'(i);

        swm_cell #(
            .WINDOW    (WINDOW),
            .AGE_W     (AGE_W),
            .RESET_AGE (WINDOW - 1 - i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (s_accept),
            .sample      (s_tdata),
            .rem_le_self (rle_self),
            .rem_le_left (rle_left),
            .left_val    (lv),
            .left_age    (la),
            .left_gt     (lg),
            .right_val   (rv),
            .right_age   (ra),
            .right_gt    (rg),
            .val         (cell_val[i]),
            .age         (cell_age[i]),
            .gt          (cell_gt[i]),
            .oldest      (cell_oldest[i])
        );
    end

    // Median taps at fixed places in the sorted chain.
    if ((WINDOW % 2) == 0) begin : g_even
        assign m_tdata_next = floor_half_sum(cell_val[WINDOW/2 - 1], cell_val[WINDOW/2]);
    end else begin : g_odd
        assign m_tdata_next = cell_val[WINDOW/2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_reg <= 1'b1;
            end else if (out_load) begin
                pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/swm_cell.sv */
// One cell of the sorted chain: holds a sample value and its age.
module swm_cell
    import swm_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEFAULT,
    parameter int AGE_W     = 3,
    parameter int RESET_AGE = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       rem_le_self,   // removed cell sits at or below this one
    input  logic                       rem_le_left,   // removed cell sits at or below the left one
    input  logic signed [SAMPLE_W-1:0] left_val,
    input  logic [AGE_W-1:0]           left_age,
    input  logic                       left_gt,
    input  logic signed [SAMPLE_W-1:0] right_val,
    input  logic [AGE_W-1:0]           right_age,
    input  logic                       right_gt,
    output logic signed [SAMPLE_W-1:0] val,
    output logic [AGE_W-1:0]           age,
    output logic                       gt,
    output logic                       oldest
);

    logic signed [SAMPLE_W-1:0] val_reg, val_next;
    logic [AGE_W-1:0]           age_reg, age_next;

    // Chain with the oldest entry taken out: c[i] and c[i-1]
    logic signed [SAMPLE_W-1:0] c_val, cl_val;
    logic [AGE_W-1:0]           c_age, cl_age;
    logic                       c_gt, cl_gt;

    assign gt     = val_reg > sample;
    assign oldest = age_reg == AGE_W'(WINDOW - 1);
    assign val    = val_reg;
    assign age    = age_reg;

    always_comb begin
        c_val  = rem_le_self ? right_val : val_reg;
        c_age  = rem_le_self ? right_age : age_reg;
        c_gt   = rem_le_self ? right_gt  : gt;
        cl_val = rem_le_left ? val_reg   : left_val;
        cl_age = rem_le_left ? age_reg   : left_age;
        cl_gt  = rem_le_left ? gt        : left_gt;
        if (!c_gt) begin
            val_next = c_val;
            age_next = c_age + 1'b1;
        end else if (cl_gt) begin
            val_next = cl_val;
            age_next = cl_age + 1'b1;
        end else begin
            val_next = sample;
            age_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            age_reg <= AGE_W'(RESET_AGE);
        end else if (shift_en) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

/* src/swm_checker.sv */
// Port-level checks for the sliding-window median filter, bound to the top level.
module swm_checker
    import swm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled output.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output stall");

    // Every accepted sample is followed by a result showing on m_tvalid.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result after accepted sample");

    // No result right out of reset.
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/testbench.sv */
// Self-checking testbench for the sliding-window running median filter.
module testbench;
    import swm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = WINDOW_DEFAULT;
    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_ITEMS   = 200;    // last stretch runs with no idling
    localparam int STALL_LIMIT  = 1000;   // cycles with no request taken on either side
    localparam int DRAIN_CYCLES = 8;      // margin after the last median, in cycles

    localparam logic [SAMPLE_W-1:0] MAX_S = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] MIN_S = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] ONE_Q = 32'h0001_0000;   // 1.0 in Q16.16

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;   // [31:0] sample
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;         // [31:0] median

    // samples waiting to be sent, and medians waiting to come out
    logic [SAMPLE_W-1:0] pending_samples[$];
    logic [SAMPLE_W-1:0] median_queue[$];

    // predictor state: ring of the last WINDOW samples and the slot written next
    logic signed [SAMPLE_W-1:0] ring_slots[WINDOW];
    int                         ring_ptr;

    logic s_fire = 1'b0;      // input request taken at the last rising edge
    int   send_gap = 0;
    int   ready_gap = 0;
    int   traffic_mode = 0;   // 0: no idling, 1: light, 2: heavy
    int   cycle_count = 0;
    int   idle_cycles = 0;
    int   errors = 0;

    sliding_window_median_top #(
        .WINDOW(WINDOW)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        $display("[%0t] mismatch: %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Insert the sample at the ring pointer, advance it, then sort a copy of the
    // ring and take its median. Even window: floor of the mean of the middle pair.
    function automatic logic [SAMPLE_W-1:0] predict_median(input logic [SAMPLE_W-1:0] sample);
        logic signed [SAMPLE_W-1:0] sorted[WINDOW];
        logic signed [SAMPLE_W-1:0] key;
        logic signed [SAMPLE_W:0]   pair_sum;
        int                         j;
        ring_slots[ring_ptr] = sample;
        ring_ptr = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;
        sorted = ring_slots;
        for (int i = 1; i < WINDOW; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (WINDOW % 2 == 0) begin
            // 33-bit signed sum cannot overflow; dropping bit 0 floors the halving
            pair_sum = sorted[(WINDOW > 1) ? WINDOW/2 - 1 : 0];
            pair_sum = pair_sum + sorted[WINDOW/2];
            return pair_sum[SAMPLE_W:1];
        end
        return sorted[WINDOW/2];
    endfunction

    // Decides whether a side starts an idle burst now; never in the tail.
    function automatic bit start_burst();
        if (pending_samples.size() < TAIL_ITEMS || traffic_mode == 0)
            return 1'b0;
        return (traffic_mode == 1) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0);
    endfunction

    // Sender: holds a request until it is taken, then moves to the next pending
    // sample unless an idle burst starts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (start_burst()) begin
                send_gap = $urandom_range(1, 5) - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_tdata  <= pending_samples.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready by default, with stall bursts; also picks the traffic mode
    // at random so that stretches with and without idling alternate.
    always @(negedge aclk) begin
        cycle_count++;
        if (cycle_count % 50 == 0)
            traffic_mode = $urandom_range(0, 2);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else if (start_burst()) begin
            ready_gap = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each taken result against the oldest predicted median,
    // predicts a new median for each taken sample, and runs the watchdog.
    always @(posedge aclk) begin : monitor
        logic [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            s_fire <= 1'b0;
            idle_cycles = 0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (median_queue.size() == 0) begin
                    report_mismatch("median with none expected", m_tdata, 'x);
                end else begin
                    want = median_queue.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("median", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready)
                median_queue.push_back(predict_median(s_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no request taken for %0d cycles, %0d medians owed",
                         $realtime, idle_cycles, median_queue.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] directed_samples[] = '{
            // window still filling: the zeros from reset dominate
            MAX_S, MIN_S, 32'hFFFF_FFFF, 32'h0000_0001, ONE_Q, -ONE_Q,
            // window full: middle pair -1 and 1, mean 0
            MAX_S, MIN_S,
            // top half saturates at the positive extreme
            MAX_S, MAX_S, MAX_S, MAX_S,
            // middle pair min and max: sum -1, floors to -1
            MIN_S, MIN_S, MIN_S, MIN_S,
            // samples of mixed sign; odd sums round toward minus infinity
            32'h0000_0003, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'h0000_0002,
            // duplicates kept as a multiset
            32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005
        };
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] last_value;
        int                  run_len;
        int                  target;

        for (int i = 0; i < WINDOW; i++)
            ring_slots[i] = '0;
        ring_ptr = 0;

        foreach (directed_samples[i])
            pending_samples.push_back(directed_samples[i]);

        // random part: full-range words, small values rich in ties, extremes,
        // Q16.16 integers, runs of equal samples and slow ramps
        target = pending_samples.size() + RANDOM_ITEMS;
        last_value = '0;
        while (pending_samples.size() < target) begin
            run_len = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = $urandom;
                4, 5:       value = SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
                6: begin
                    case ($urandom_range(0, 3))
                        0:       value = MAX_S;
                        1:       value = MIN_S;
                        2:       value = '0;
                        default: value = '1;
                    endcase
                end
                7: value = (SAMPLE_W'($urandom_range(0, 20)) - SAMPLE_W'(10)) << 16;
                8: begin
                    value = $urandom;
                    run_len = $urandom_range(2, WINDOW);
                end
                default: value = last_value + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
            endcase
            for (int k = 0; k < run_len; k++)
                pending_samples.push_back(value);
            last_value = value;
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // all samples sent and taken, then every median back, then a short drain
        while (pending_samples.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (median_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median_top.sv
src/swm_checker.sv
sim/testbench.sv
